// ===== rtl/core/adc_average_hysteresis_filter_top_assert.svh =====
// ----------------------------------------------------------------------------
// ADC average hysteresis filter assertion macros
// Clocked property wrappers shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ADC_AVERAGE_HYSTERESIS_FILTER_TOP_ASSERT_SVH
`define ADC_AVERAGE_HYSTERESIS_FILTER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AAHF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define AAHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/aahf_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC average hysteresis filter package
// Sizes and reset constants of the filter.
// ----------------------------------------------------------------------------
package aahf_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int WINDOW_LEN   = 8;
   localparam int SLOT_BITS    = $clog2(WINDOW_LEN);
   localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
   localparam int THRESH_BITS  = 10;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(20);
   localparam logic [SLOT_BITS-1:0]   SLOT_LAST    = SLOT_BITS'(WINDOW_LEN - 1);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [SUM_BITS-1:0]    sum_type;
   typedef logic [THRESH_BITS-1:0] thresh_type;

endpackage

// ===== rtl/core/adc_average_hysteresis_filter_top.sv =====
// ----------------------------------------------------------------------------
// ADC average hysteresis filter
// Moving average over a ring of samples plus a hysteresis-smoothed value.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one ADC sample per transfer (valid/ready).
//   rsp_* returns one result per sample: the truncated window mean and the
//   smoothed value, in sample order.
//   csr_wr_en/csr_wr_data load the jump threshold; write only while idle.
// Path: the sample is registered in the read stage with the old slot content,
//   then the result in the output register; a stall holds it in the read stage.
// Throughput: one sample per cycle while rsp_ready stays high; the ring memory
//   has a single read port and the old slot content is read once per sample.
// Reset: ring entries read as zero until written (per-entry valid bits),
//   write slot, running sum and smoothed value clear, threshold loads 20.
//   No clearing pass is needed; samples are taken right after reset.
// Stall: when rsp_ready is low the output register holds, the read stage
//   holds its registered memory data, and req_ready drops once both are full.
// ----------------------------------------------------------------------------
`include "adc_average_hysteresis_filter_top_assert.svh"

module adc_average_hysteresis_filter_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [aahf_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [aahf_pkg::SAMPLE_BITS-1:0] rsp_window_mean,
   output logic [aahf_pkg::SAMPLE_BITS-1:0] rsp_smoothed_value,
   input  logic                         csr_wr_en,
   input  logic [aahf_pkg::THRESH_BITS-1:0] csr_wr_data
);

   aahf_pkg::sample_type ring_mem [aahf_pkg::WINDOW_LEN];

   logic [aahf_pkg::WINDOW_LEN-1:0] entry_valid_ff;
   aahf_pkg::slot_type   slot_ff, slot_in;
   aahf_pkg::sum_type    sum_ff, sum_in;
   aahf_pkg::sample_type smooth_ff, smooth_in;
   aahf_pkg::thresh_type thresh_ff;

   logic                 s1_valid_ff;
   aahf_pkg::sample_type s1_sample_ff;
   aahf_pkg::slot_type   s1_slot_ff;
   aahf_pkg::sample_type old_data_ff;
   logic                 old_valid_ff;

   logic                 rsp_valid_ff;
   aahf_pkg::sample_type rsp_mean_ff, rsp_mean_in;
   aahf_pkg::sample_type rsp_smooth_ff;

   logic                 req_xfer;
   logic                 s1_adv;
   logic                 out_free;
   aahf_pkg::sample_type old_sample;
   aahf_pkg::sample_type diff;
   logic [aahf_pkg::SAMPLE_BITS:0] pair_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   assign slot_in = (slot_ff == aahf_pkg::SLOT_LAST) ? '0 : slot_ff + 1'b1;

   // read-modify-write: old slot content is registered from memory with the sample
   always_comb begin
      old_sample = old_valid_ff ? old_data_ff : '0;
      sum_in     = sum_ff - aahf_pkg::SUM_BITS'(old_sample)
                 + aahf_pkg::SUM_BITS'(s1_sample_ff);
      rsp_mean_in = aahf_pkg::SAMPLE_BITS'(sum_in / aahf_pkg::WINDOW_LEN);
      diff = (s1_sample_ff > smooth_ff) ? (s1_sample_ff - smooth_ff)
                                        : (smooth_ff - s1_sample_ff);
      pair_sum = {1'b0, smooth_ff} + {1'b0, s1_sample_ff};
      if (aahf_pkg::THRESH_BITS'(diff) > thresh_ff) begin
         smooth_in = s1_sample_ff;
      end else begin
         smooth_in = pair_sum[aahf_pkg::SAMPLE_BITS:1];
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         old_data_ff <= ring_mem[slot_ff];
      end
      if (s1_adv) begin
         ring_mem[s1_slot_ff] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         slot_ff        <= '0;
         sum_ff         <= '0;
         smooth_ff      <= '0;
         thresh_ff      <= aahf_pkg::THRESH_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            slot_ff <= slot_in;
         end
         if (s1_adv) begin
            entry_valid_ff[s1_slot_ff] <= 1'b1;
            sum_ff    <= sum_in;
            smooth_ff <= smooth_in;
         end
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sample_ff <= req_sample;
         s1_slot_ff   <= slot_ff;
         old_valid_ff <= entry_valid_ff[slot_ff];
      end
      if (s1_adv) begin
         rsp_mean_ff   <= rsp_mean_in;
         rsp_smooth_ff <= smooth_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_mean    = rsp_mean_ff;
   assign rsp_smoothed_value = rsp_smooth_ff;

   `AAHF_ASSERT_NOW(a_no_rw_same_slot, clock, reset, req_xfer && s1_adv, slot_ff != s1_slot_ff, "ring read and write hit the same slot")
   `AAHF_ASSERT_NEXT(a_xfer_fills_s1, clock, reset, req_xfer, s1_valid_ff, "transfer did not reach the read stage")
   `AAHF_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_sample_ff), "read stage dropped a stalled sample")
   `AAHF_ASSERT_NEXT(a_slot_advance, clock, reset, req_xfer, slot_ff == (($past(slot_ff) == aahf_pkg::SLOT_LAST) ? '0 : $past(slot_ff) + 1'b1), "write slot did not advance")

endmodule

// ===== tb/adc_average_hysteresis_filter_top_test.sv =====
// ----------------------------------------------------------------------------
// ADC average hysteresis filter testbench
// Drives ADC samples through valid/ready with random idle and stall bursts,
// predicts the eight-sample window mean and the hysteresis-smoothed value,
// and checks every result in order. The jump threshold is reloaded between
// phases once the filter has drained, covering both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_average_hysteresis_filter_top_test;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct packed {
      aahf_pkg::sample_type window_mean;
      aahf_pkg::sample_type smoothed_value;
   } filter_result_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   aahf_pkg::sample_type req_sample  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   aahf_pkg::sample_type rsp_window_mean;
   aahf_pkg::sample_type rsp_smoothed_value;
   logic                 csr_wr_en   = 1'b0;
   aahf_pkg::thresh_type csr_wr_data = '0;

   aahf_pkg::sample_type pending_samples[$];
   filter_result_type    expected_results[$];

   aahf_pkg::sample_type ring_model[aahf_pkg::WINDOW_LEN];
   aahf_pkg::slot_type   next_slot       = '0;
   aahf_pkg::sum_type    window_sum      = '0;
   aahf_pkg::sample_type smooth_model    = '0;
   aahf_pkg::thresh_type threshold_model = aahf_pkg::THRESH_RESET;

   int mismatch_count = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit idle_enable    = 1'b1;

   adc_average_hysteresis_filter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_mean    (rsp_window_mean),
      .rsp_smoothed_value (rsp_smoothed_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   function automatic filter_result_type predict_filter(input aahf_pkg::sample_type s);
      filter_result_type              res;
      aahf_pkg::sample_type           delta;
      logic [aahf_pkg::SAMPLE_BITS:0] pair_sum;
      window_sum             = window_sum - ring_model[next_slot] + s;
      ring_model[next_slot]  = s;
      next_slot              = (next_slot == aahf_pkg::SLOT_LAST) ? '0 : next_slot + 1'b1;
      delta = (s > smooth_model) ? s - smooth_model : smooth_model - s;
      if (delta > threshold_model) begin
         smooth_model = s;
      end else begin
         pair_sum     = {1'b0, smooth_model} + {1'b0, s};
         smooth_model = pair_sum[aahf_pkg::SAMPLE_BITS:1];
      end
      res.window_mean    = aahf_pkg::sample_type'(window_sum / aahf_pkg::WINDOW_LEN);
      res.smoothed_value = smooth_model;
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_results.push_back(predict_filter(req_sample));
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            req_valid  <= 1'b1;
            req_sample <= pending_samples.pop_front();
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor_proc
      filter_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer mean %0d smoothed %0d",
                                         rsp_window_mean, rsp_smoothed_value));
            end else begin
               want = expected_results.pop_front();
               if (rsp_window_mean !== want.window_mean)
                  report_mismatch($sformatf("window_mean got %0d want %0d",
                                            rsp_window_mean, want.window_mean));
               if (rsp_smoothed_value !== want.smoothed_value)
                  report_mismatch($sformatf("smoothed_value got %0d want %0d",
                                            rsp_smoothed_value, want.smoothed_value));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic drain_filter();
      while (pending_samples.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_threshold(input aahf_pkg::thresh_type value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      threshold_model = value;
   endtask

   initial begin
      int                   lvl;
      int                   span;
      int                   val;
      int                   kind;
      aahf_pkg::thresh_type th;
      aahf_pkg::sample_type directed[$];

      foreach (ring_model[k]) ring_model[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ring fill and wrap, threshold edge at reset value 20, bit patterns
      directed = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                   10'd1023, 10'd1023, 10'd1023, 10'd1003, 10'd992, 10'd0,
                   10'd0, 10'd512, 10'd531, 10'd341, 10'd682, 10'd1, 10'd1022,
                   10'd0, 10'd20, 10'd41};
      foreach (directed[k]) pending_samples.push_back(directed[k]);
      drain_filter();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: th = '0;
            1: th = '1;
            2: th = 10'd1;
            3: th = 10'd7;
            4: th = 10'd64;
            7: th = aahf_pkg::THRESH_RESET;
            default: th = aahf_pkg::thresh_type'($urandom_range(0, 1023));
         endcase
         load_threshold(th);
         idle_enable = (ph % 3 != 2) && (ph != PHASES - 1);
         lvl = $urandom_range(0, 1023);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
               val = $urandom_range(0, 1023);
            end else if (kind == 3) begin
               val = ($urandom_range(0, 1) == 1) ? 1023 : 0;
            end else begin
               if ($urandom_range(0, 15) == 0) lvl = $urandom_range(0, 1023);
               span = int'(th) + 2;
               val  = lvl + int'($urandom_range(0, 2 * span)) - span;
               if (val < 0) val = 0;
               if (val > 1023) val = 1023;
            end
            pending_samples.push_back(aahf_pkg::sample_type'(val));
         end
         drain_filter();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
